// File: design/vdma_pkg.sv
// Package for the VRAM DMA controller: mode codes, command kinds, the queued
// command record and the fixed constants. No dependencies.
package vdma_pkg;

    // Mode codes of an incoming item.
    localparam logic [1:0] MODE_WRITE_SRC = 2'd0;
    localparam logic [1:0] MODE_WRITE_DST = 2'd1;
    localparam logic [1:0] MODE_START     = 2'd2;
    localparam logic [1:0] MODE_HBLANK    = 2'd3;

    // Fixed constants of the transfer engine.
    localparam logic [2:0]  VRAM_BASE_TOP = 3'b100;    // 0x8000 in the top three bits
    localparam logic [15:0] VRAM_BASE     = 16'h8000;
    localparam logic [11:0] CHUNK_BYTES   = 12'd16;
    localparam logic [6:0]  LEN_DONE      = 7'h7f;

    // Command kinds after classification by the front end.
    typedef enum logic [2:0] {
        CMD_SET_SRC,
        CMD_SET_DST,
        CMD_GENERAL,
        CMD_ARM,
        CMD_ARM_CHUNK,
        CMD_HBLANK
    } cmd_kind_t;

    // One queued command.
    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] address_value;
        logic [6:0]  blocks_minus_one;
    } cmd_t;

endpackage

// File: design/vdma_in_if.sv
// Request channel of the VRAM DMA controller: valid/ready plus the item fields.
// No dependencies.
interface vdma_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] address_value;
    logic [6:0]  blocks_minus_one;
    logic        hblank_mode;
    logic        display_in_hblank;

    modport source (
        output valid, mode, address_value, blocks_minus_one, hblank_mode,
               display_in_hblank,
        input  ready
    );
    modport sink (
        input  valid, mode, address_value, blocks_minus_one, hblank_mode,
               display_in_hblank,
        output ready
    );
endinterface

// File: design/vdma_out_if.sv
// Result channel of the VRAM DMA controller: valid/ready plus the copy range.
// No dependencies.
interface vdma_out_if;
    logic        valid;
    logic        ready;
    logic        copy_valid;
    logic [15:0] copy_source;
    logic [15:0] copy_vram_start;
    logic [11:0] copy_bytes;
    logic [12:0] cycles_used;
    logic        hblank_armed;
    logic [6:0]  blocks_left;

    modport source (
        output valid, copy_valid, copy_source, copy_vram_start, copy_bytes,
               cycles_used, hblank_armed, blocks_left,
        input  ready
    );
    modport sink (
        input  valid, copy_valid, copy_source, copy_vram_start, copy_bytes,
               cycles_used, hblank_armed, blocks_left,
        output ready
    );
endinterface

// File: design/vram_dma_controller_unit.sv
// Top level of the VRAM DMA controller: front end, command queue and back end.
// Depends on vdma_pkg, vdma_in_if, vdma_out_if, vdma_front, vdma_fifo, vdma_back.
//
//   Channel  Role    Carries
//   req      sink    mode, address_value, blocks_minus_one, hblank_mode,
//                    display_in_hblank
//   rsp      source  copy_valid, copy_source, copy_vram_start, copy_bytes,
//                    cycles_used, hblank_armed, blocks_left
//
// One item per cycle sustained while the queue has room and rsp does not stall;
// each item yields exactly one result. With an empty queue an accepted item is
// written into the queue and then into the result register, where its result is valid.
// The queue holds QUEUE_DEPTH commands; req.ready falls only when it is full.
// Reset clears addresses to zero, the length to 127 and the HBlank arm flag.
// A stall on rsp holds the result register and lets the queue fill behind it.
module vram_dma_controller_unit
    import vdma_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    vdma_in_if.sink    req,
    vdma_out_if.source rsp
);

    logic push;
    logic pop;
    logic full;
    logic head_valid;
    cmd_t push_cmd;
    cmd_t head_cmd;

    vdma_front u_front (
        .req      (req),
        .full     (full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    vdma_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    vdma_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .rsp        (rsp)
    );

endmodule

// File: design/vdma_front.sv
// Front end of the VRAM DMA controller: accepts request items and classifies
// them into queued commands. Depends on vdma_pkg and vdma_in_if.
module vdma_front
    import vdma_pkg::*;
(
    vdma_in_if.sink req,
    input  logic    full,
    output logic    push,
    output cmd_t    push_cmd
);

    // An item is taken whenever the queue has room.
    assign req.ready = !full;
    assign push      = req.valid && !full;

    // Classify the item by mode and start flavor.
    always_comb
    begin
        push_cmd.address_value    = req.address_value;
        push_cmd.blocks_minus_one = req.blocks_minus_one;
        case (req.mode)
            MODE_WRITE_SRC: push_cmd.kind = CMD_SET_SRC;
            MODE_WRITE_DST: push_cmd.kind = CMD_SET_DST;
            MODE_START:
            begin
                if (!req.hblank_mode)
                    push_cmd.kind = CMD_GENERAL;
                else if (req.display_in_hblank)
                    push_cmd.kind = CMD_ARM_CHUNK;
                else
                    push_cmd.kind = CMD_ARM;
            end
            MODE_HBLANK:    push_cmd.kind = CMD_HBLANK;
            default:        push_cmd.kind = CMD_HBLANK;
        endcase
    end

endmodule

// File: design/vdma_fifo.sv
// Short command queue between the front and back ends of the VRAM DMA
// controller. Depends on vdma_pkg.
module vdma_fifo
    import vdma_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_cmd;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue fill count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> !pop)
        else $error("pop from an empty queue");
`endif

endmodule

// File: design/vdma_back.sv
// Back end of the VRAM DMA controller: holds the address, length and arm state,
// carries out queued commands and registers one result per command.
// Depends on vdma_pkg and vdma_out_if.
module vdma_back
    import vdma_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic head_valid,
    input  cmd_t head_cmd,
    output logic pop,
    vdma_out_if.source rsp
);

    logic [15:0] src_reg, src_next;
    logic [15:0] dst_reg, dst_next;
    logic [6:0]  len_reg, len_next;
    logic        armed_reg, armed_next;

    logic        out_valid_reg, out_valid_next;
    logic        copy_valid_reg;
    logic [15:0] copy_source_reg;
    logic [15:0] copy_vram_reg;
    logic [11:0] copy_bytes_reg;
    logic [12:0] cycles_reg;
    logic        armed_out_reg;
    logic [6:0]  left_out_reg;

    logic        do_copy;
    logic        do_chunk;
    logic [11:0] bytes;
    logic [6:0]  chunk_len;
    logic [7:0]  blocks_plus_one;

    // A command is taken when the output register is free or being drained.
    assign pop = head_valid && (!out_valid_reg || rsp.ready);

    assign blocks_plus_one = {1'b0, head_cmd.blocks_minus_one} + 8'd1;

    // Execute one command against the current state.
    always_comb
    begin
        src_next   = src_reg;
        dst_next   = dst_reg;
        len_next   = len_reg;
        armed_next = armed_reg;
        do_copy    = 1'b0;
        do_chunk   = 1'b0;
        bytes      = '0;
        chunk_len  = len_reg;
        case (head_cmd.kind)
            CMD_SET_SRC: src_next = head_cmd.address_value;
            CMD_SET_DST: dst_next = head_cmd.address_value;
            CMD_GENERAL:
            begin
                do_copy    = 1'b1;
                bytes      = {blocks_plus_one, 4'b0000};
                armed_next = 1'b0;
                len_next   = LEN_DONE;
            end
            CMD_ARM:
            begin
                armed_next = 1'b1;
                len_next   = head_cmd.blocks_minus_one;
            end
            CMD_ARM_CHUNK:
            begin
                armed_next = 1'b1;
                chunk_len  = head_cmd.blocks_minus_one;
                do_chunk   = 1'b1;
            end
            CMD_HBLANK:
            begin
                do_chunk = armed_reg;
            end
            default:
            begin
                do_copy = 1'b0;
            end
        endcase

        // A chunk moves 16 bytes and counts the length down.
        if (do_chunk)
        begin
            do_copy = 1'b1;
            bytes   = CHUNK_BYTES;
            if (chunk_len == '0)
            begin
                armed_next = 1'b0;
                len_next   = LEN_DONE;
            end
            else
            begin
                len_next = chunk_len - 7'd1;
            end
        end

        if (do_copy)
        begin
            src_next = src_reg + {4'b0000, bytes};
            dst_next = dst_reg + {4'b0000, bytes};
        end
    end

    // Output handshake state.
    always_comb
    begin
        if (pop)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg       <= '0;
            dst_reg       <= '0;
            len_reg       <= LEN_DONE;
            armed_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                src_reg   <= src_next;
                dst_reg   <= dst_next;
                len_reg   <= len_next;
                armed_reg <= armed_next;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            copy_valid_reg  <= do_copy;
            copy_source_reg <= do_copy ? src_reg : 16'd0;
            copy_vram_reg   <= do_copy ? {VRAM_BASE_TOP, dst_reg[12:0]} : VRAM_BASE;
            copy_bytes_reg  <= bytes;
            cycles_reg      <= {bytes, 1'b0};
            armed_out_reg   <= armed_next;
            left_out_reg    <= len_next;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.copy_valid      = copy_valid_reg;
    assign rsp.copy_source     = copy_source_reg;
    assign rsp.copy_vram_start = copy_vram_reg;
    assign rsp.copy_bytes      = copy_bytes_reg;
    assign rsp.cycles_used     = cycles_reg;
    assign rsp.hblank_armed    = armed_out_reg;
    assign rsp.blocks_left     = left_out_reg;

`ifndef SYNTHESIS
    a_idle_length: assert property (@(posedge clk) disable iff (!rst_n)
        !armed_reg |-> (len_reg == LEN_DONE))
        else $error("length not parked while no HBlank transfer is armed");

    a_copy_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && do_copy) |=> (src_reg - $past(src_reg)) == (dst_reg - $past(dst_reg)))
        else $error("source and destination advanced by different amounts");

    a_no_copy_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !copy_valid_reg) |->
            (copy_bytes_reg == '0 && copy_source_reg == '0 && copy_vram_reg == VRAM_BASE))
        else $error("result without a copy carries a nonzero range");
`endif

endmodule

// File: sim/tb_vram_dma_controller_unit.sv
// Self-checking testbench for vram_dma_controller_unit: directed and random items,
// with every result checked against a predictor kept inside the testbench.
// Depends on vdma_pkg, vdma_in_if, vdma_out_if and the controller RTL.
`timescale 1ns / 100ps

module tb_vram_dma_controller_unit;
    import vdma_pkg::*;

    // Generous bound, far above what about 1200 items need.
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_CYCLES = 8;

    // One copy range as the result channel reports it.
    typedef struct packed {
        logic        copy_valid;
        logic [15:0] copy_source;
        logic [15:0] copy_vram_start;
        logic [11:0] copy_bytes;
        logic [12:0] cycles_used;
        logic        hblank_armed;
        logic [6:0]  blocks_left;
    } copy_range_t;

    logic clk = 1'b0;
    logic rst_n;

    vdma_in_if  req ();
    vdma_out_if rsp ();

    vram_dma_controller_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // Shadow copy of the controller's registers.
    logic [15:0] src_addr = 16'h0000;
    logic [15:0] dst_addr = 16'h0000;
    logic [6:0]  len_blocks = LEN_DONE;
    logic        hb_armed = 1'b0;

    copy_range_t expected_ranges[$];

    int unsigned mismatches = 0;
    int unsigned items_sent = 0;
    int unsigned effective_items = 0;
    int unsigned results_seen = 0;
    int unsigned general_copies = 0;
    int unsigned chunk_copies = 0;
    int unsigned hblank_ends = 0;
    int unsigned preempted = 0;
    int unsigned ignored_hblanks = 0;

    // Sender burst state.
    int unsigned burst_left = 0;
    bit          sender_idle = 1'b1;

    logic [31:0] cycle_count = 32'd0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Move a byte range and advance both addresses, wrapping at 64 KiB.
    function automatic void move_bytes(inout copy_range_t r, input logic [11:0] nbytes);
        r.copy_valid      = 1'b1;
        r.copy_source     = src_addr;
        r.copy_vram_start = VRAM_BASE | 16'(dst_addr[12:0]);
        r.copy_bytes      = nbytes;
        r.cycles_used     = 13'(nbytes) << 1;
        src_addr = src_addr + 16'(nbytes);
        dst_addr = dst_addr + 16'(nbytes);
    endfunction

    // One 16-byte chunk; the last one ends the armed transfer.
    function automatic void move_chunk(inout copy_range_t r);
        move_bytes(r, CHUNK_BYTES);
        chunk_copies++;
        if (len_blocks == 7'd0)
        begin
            hb_armed   = 1'b0;
            len_blocks = LEN_DONE;
            hblank_ends++;
        end
        else
        begin
            len_blocks = len_blocks - 7'd1;
        end
    endfunction

    // Update the shadow registers for one accepted item and return its result.
    function automatic copy_range_t predict_range(input logic [1:0] mode,
                                                  input logic [15:0] addr,
                                                  input logic [6:0] blocks,
                                                  input logic hbm,
                                                  input logic in_hblank);
        copy_range_t r;
        r = '0;
        r.copy_vram_start = VRAM_BASE;
        effective_items++;
        case (mode)
            MODE_WRITE_SRC: src_addr = addr;
            MODE_WRITE_DST: dst_addr = addr;
            MODE_START:
            begin
                len_blocks = blocks;
                if (hbm)
                begin
                    hb_armed = 1'b1;
                    if (in_hblank)
                    begin
                        move_chunk(r);
                    end
                end
                else
                begin
                    if (hb_armed)
                    begin
                        preempted++;
                    end
                    move_bytes(r, (12'(blocks) + 12'd1) * CHUNK_BYTES);
                    general_copies++;
                    hb_armed   = 1'b0;
                    len_blocks = LEN_DONE;
                end
            end
            default:
            begin
                if (hb_armed)
                begin
                    move_chunk(r);
                end
                else
                begin
                    ignored_hblanks++;
                    effective_items--;
                end
            end
        endcase
        r.hblank_armed = hb_armed;
        r.blocks_left  = len_blocks;
        return r;
    endfunction

    // Drive one item, starting at a rising edge, and return at the edge that accepts it.
    task automatic send_item(input logic [1:0] mode, input logic [15:0] addr,
                             input logic [6:0] blocks, input logic hbm,
                             input logic in_hblank);
        bit          rdy;
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = sender_idle ? $urandom_range(1, 6) : 0;
            if (gap != 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req.valid             <= 1'b1;
        req.mode              <= mode;
        req.address_value     <= addr;
        req.blocks_minus_one  <= blocks;
        req.hblank_mode       <= hbm;
        req.display_in_hblank <= in_hblank;
        // Ready is sampled mid-cycle, where no input is changing.
        do
        begin
            @(negedge clk);
            rdy = req.ready;
            @(posedge clk);
        end
        while (!rdy);
        expected_ranges.push_back(predict_range(mode, addr, blocks, hbm, in_hblank));
        items_sent++;
    endtask

    task automatic send_random_item();
        send_item(2'($urandom), 16'($urandom), 7'($urandom), 1'($urandom), 1'($urandom));
    endtask

    // Receiver: held off during reset, then a stall pattern that steps with
    // cycle_count[8:6], from none to heavy.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 32'd1;
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
        end
        else
        begin
            case (cycle_count[8:6])
                3'd0, 3'd1: rsp.ready <= 1'b1;
                3'd2:       rsp.ready <= ($urandom_range(0, 3) != 0);
                3'd3:       rsp.ready <= 1'($urandom);
                3'd4:       rsp.ready <= ((cycle_count % 7) >= 3);
                3'd5:       rsp.ready <= (cycle_count[3:0] == 4'd0);
                default:    rsp.ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    task automatic check_field(input string name, input int unsigned expv,
                               input int unsigned actv);
        if (expv != actv)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, expv, actv);
            mismatches++;
        end
    endtask

    // Result checker: valid and ready seen mid-cycle mean a handshake at the next edge.
    always @(negedge clk)
    begin : check_results
        copy_range_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            results_seen++;
            if (expected_ranges.size() == 0)
            begin
                $display("%0t: result with no item pending, expected none, actual source 0x%0h",
                         $time, rsp.copy_source);
                mismatches++;
            end
            else
            begin
                want = expected_ranges.pop_front();
                check_field("copy_valid", 32'(want.copy_valid), 32'(rsp.copy_valid));
                check_field("copy_source", 32'(want.copy_source), 32'(rsp.copy_source));
                check_field("copy_vram_start", 32'(want.copy_vram_start),
                            32'(rsp.copy_vram_start));
                check_field("copy_bytes", 32'(want.copy_bytes), 32'(rsp.copy_bytes));
                check_field("cycles_used", 32'(want.cycles_used), 32'(rsp.cycles_used));
                check_field("hblank_armed", 32'(want.hblank_armed), 32'(rsp.hblank_armed));
                check_field("blocks_left", 32'(want.blocks_left), 32'(rsp.blocks_left));
            end
        end
    end

    // An HBlank right after reset is ignored.
    task automatic test_idle_hblank();
        send_item(MODE_HBLANK, 16'hffff, 7'h7f, 1'b1, 1'b1);
        send_item(MODE_HBLANK, 16'h0000, 7'h00, 1'b0, 1'b0);
    endtask

    // General copies at the address and length extremes, wrapping both address spaces.
    task automatic test_general_copies();
        send_item(MODE_WRITE_SRC, 16'hffff, 7'h7f, 1'b1, 1'b1);
        send_item(MODE_WRITE_DST, 16'hffff, 7'h7f, 1'b1, 1'b1);
        send_item(MODE_START, 16'hffff, 7'h00, 1'b0, 1'b1);
        send_item(MODE_START, 16'h0000, 7'h7f, 1'b0, 1'b0);
        send_item(MODE_WRITE_SRC, 16'h8000, 7'h55, 1'b0, 1'b0);
        send_item(MODE_WRITE_DST, 16'h1ff8, 7'h2a, 1'b1, 1'b0);
        send_item(MODE_START, 16'h5555, 7'h7f, 1'b0, 1'b1);
    endtask

    // Chunked transfers: armed without and with an immediate chunk, ended by the
    // last chunk or cut short by a general start, then a stray HBlank.
    task automatic test_hblank_chunks();
        send_item(MODE_WRITE_SRC, 16'h0000, 7'h7f, 1'b1, 1'b1);
        send_item(MODE_WRITE_DST, 16'h0000, 7'h00, 1'b0, 1'b1);
        send_item(MODE_START, 16'haaaa, 7'h01, 1'b1, 1'b0);
        repeat (3) send_item(MODE_HBLANK, 16'hffff, 7'h7f, 1'b0, 1'b1);
        send_item(MODE_START, 16'h0000, 7'h00, 1'b1, 1'b1);
        send_item(MODE_HBLANK, 16'h0000, 7'h00, 1'b1, 1'b0);
        send_item(MODE_START, 16'h0000, 7'h02, 1'b1, 1'b1);
        send_item(MODE_START, 16'hffff, 7'h03, 1'b0, 1'b1);
        send_item(MODE_HBLANK, 16'h1234, 7'h11, 1'b1, 1'b1);
        send_item(MODE_START, 16'h0000, 7'h7f, 1'b1, 1'b0);
        send_item(MODE_HBLANK, 16'h0000, 7'h00, 1'b0, 1'b0);
        send_item(MODE_START, 16'h0000, 7'h05, 1'b0, 1'b0);
    endtask

    // Well-formed transfers with random content, with some noise mixed in.
    task automatic test_random_transfers(input int unsigned count);
        int unsigned stop_at;
        int unsigned n_events;
        logic [6:0]  blk;
        logic        hbm;
        logic [15:0] dst;
        stop_at = effective_items + count;
        while (effective_items < stop_at)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                sender_idle = !sender_idle;
            end
            if ($urandom_range(0, 4) != 0)
            begin
                send_item(MODE_WRITE_SRC, 16'($urandom), 7'($urandom), 1'($urandom),
                          1'($urandom));
            end
            if ($urandom_range(0, 4) != 0)
            begin
                // A third of the destinations sit just below an 8 KiB boundary.
                dst = 16'($urandom);
                if ($urandom_range(0, 2) == 0)
                begin
                    dst = dst | 16'h1ff0;
                end
                send_item(MODE_WRITE_DST, dst, 7'($urandom), 1'($urandom), 1'($urandom));
            end
            hbm = ($urandom_range(0, 9) < 6);
            case ($urandom_range(0, 19))
                0:       blk = 7'h7f;
                1, 2:    blk = 7'($urandom);
                default: blk = 7'($urandom_range(0, 5));
            endcase
            send_item(MODE_START, 16'($urandom), blk, hbm, 1'($urandom));
            if (hbm)
            begin
                // Usually run to the end and a little past; sometimes stop early.
                n_events = blk + 1 + $urandom_range(0, 2);
                if ($urandom_range(0, 5) == 0)
                begin
                    n_events = $urandom_range(0, blk);
                end
                repeat (n_events)
                begin
                    send_item(MODE_HBLANK, 16'($urandom), 7'($urandom), 1'($urandom),
                              1'($urandom));
                end
            end
            if ($urandom_range(0, 5) == 0)
            begin
                send_random_item();
            end
        end
    endtask

    // Unstructured items with every field random.
    task automatic test_random_noise(input int unsigned count);
        int unsigned stop_at;
        stop_at = effective_items + count;
        sender_idle = 1'b1;
        while (effective_items < stop_at)
        begin
            send_random_item();
        end
    endtask

    initial
    begin
        req.valid             <= 1'b0;
        req.mode              <= MODE_WRITE_SRC;
        req.address_value     <= 16'h0000;
        req.blocks_minus_one  <= 7'h00;
        req.hblank_mode       <= 1'b0;
        req.display_in_hblank <= 1'b0;
        rst_n                 <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_hblank();
        test_general_copies();
        test_hblank_chunks();
        test_random_transfers(950);
        test_random_noise(150);

        req.valid <= 1'b0;
        while (expected_ranges.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d items and %0d results: %0d general copies (%0d cut an",
                 items_sent, results_seen, general_copies, preempted);
        $display("armed transfer short), %0d chunks, %0d completed chunked transfers,",
                 chunk_copies, hblank_ends);
        $display("%0d stray HBlanks.", ignored_hblanks);
        if (mismatches == 0)
        begin
            $display("[vram_dma_controller_unit] OK");
        end
        else
        begin
            $display("[vram_dma_controller_unit] ERROR");
        end
        $finish;
    end

    // Watchdog.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("%0t: timeout with %0d results still pending", $time, expected_ranges.size());
        $display("[vram_dma_controller_unit] ERROR");
        $finish;
    end

endmodule
